// File: rtl/core/tcp_pkg.sv
package tcp_pkg;

    localparam int PREFIX_LEN    = 8;
    localparam int NAME_COUNT    = 9;
    localparam int NAME_MAX      = 10;
    localparam int FRAC_KEEP     = 6;
    localparam int FRAC_CNT_W    = 3;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_VALUE = 2'd1,
        PH_LONG  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MATCH = 3'd1,
        ST_CONV  = 3'd2,
        ST_DIV   = 3'd3,
        ST_SUM   = 3'd4,
        ST_OUT   = 3'd5
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take_byte;
        logic match_step;
        logic conv_start;
        logic div_step;
        logic sum_load;
        logic clear;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic close_result;
        logic close_error;
        logic match_last;
        logic div_last;
    } dp_sts_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = "[";
            3'd1:    c = "s";
            3'd2:    c = "l";
            3'd3:    c = "i";
            3'd4:    c = "d";
            3'd5:    c = "e";
            3'd6:    c = "r";
            default: c = ",";
        endcase
        return c;
    endfunction

    function automatic logic [NAME_MAX*8-1:0] name_text(input logic [3:0] k);
        logic [NAME_MAX*8-1:0] s;
        case (k)
            4'd0:    s = {"image_", "kp_a"};
            4'd1:    s = {"image_", "kp_b"};
            4'd2:    s = {"image_", "kd", 16'h0};
            4'd3:    s = {"IMU_kp", 32'h0};
            4'd4:    s = {"IMU_ki", 32'h0};
            4'd5:    s = {"IMU_kd", 32'h0};
            4'd6:    s = {"motor_", "kp_a"};
            4'd7:    s = {"motor_", "kp_b"};
            default: s = {"motor_", "kd", 16'h0};
        endcase
        return s;
    endfunction

    function automatic logic [3:0] name_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            4'd0, 4'd1, 4'd6, 4'd7: n = 4'd10;
            4'd2, 4'd8:             n = 4'd8;
            default:                n = 4'd6;
        endcase
        return n;
    endfunction

    function automatic logic [19:0] pow_ten(input logic [2:0] k);
        logic [19:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            default: p = 20'd1000000;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/tcp_stream_if.sv
interface tcp_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tcp_result_if.sv
interface tcp_result_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  param_index;
    logic signed [31:0] param_value;
    logic               name_error;

    modport source (output valid, output param_index, output param_value,
                    output name_error, input ready);
    modport sink   (input valid, input param_index, input param_value,
                    input name_error, output ready);
endinterface

// File: rtl/core/tuning_command_parser.sv
// Channel  Dir  Beat payload
// rx       in   rx_byte[7:0]
// res      out  param_index[3:0], param_value[31:0] signed, name_error
//
// Ordinary bytes are accepted whenever the controller is idle. A closing
// bracket with a good frame runs the name search, a start step, the fraction
// divider and a saturation step before the result beat is offered. Reset is
// asynchronous and clears all framing state. While a result waits, rx is
// stalled; the frame is cleared when the result beat is taken.
module tuning_command_parser
    import tcp_pkg::*;
#(
    parameter int LINE_BYTES    = 80,
    parameter int FIELD_CHARS   = 15,
    parameter int FRACTION_BITS = 16
)
(
    input logic         clk,
    input logic         rst_n,
    tcp_stream_if.sink  rx,
    tcp_result_if.source res
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    tcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tcp_datapath #(
        .LINE_BYTES    (LINE_BYTES),
        .FIELD_CHARS   (FIELD_CHARS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx.data),
        .cmd         (cmd),
        .sts         (sts),
        .param_index (res.param_index),
        .param_value (res.param_value),
        .name_error  (res.name_error)
    );

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx.ready && res.valid))
        else $error("input taken while a result waits");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.name_error |-> res.param_index == '0 && res.param_value == '0)
        else $error("error result carries payload");

    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.param_index <= 4'(NAME_COUNT - 1))
        else $error("index out of range");

    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready |=> rx.ready)
        else $error("input not resumed after result");

endmodule

// File: rtl/core/tcp_ctrl.sv
module tcp_ctrl
    import tcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.close_result)
                begin
                    state_next = sts.close_error ? ST_OUT : ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (sts.match_last)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid;
            end
            ST_MATCH: cmd.match_step = 1'b1;
            ST_CONV:  cmd.conv_start = 1'b1;
            ST_DIV:   cmd.div_step   = 1'b1;
            ST_SUM:   cmd.sum_load   = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.clear = out_ready;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/tcp_datapath.sv
module tcp_datapath
    import tcp_pkg::*;
#(
    parameter int LINE_BYTES    = 80,
    parameter int FIELD_CHARS   = 15,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    output logic [3:0]         param_index,
    output logic signed [31:0] param_value,
    output logic               name_error
);

    localparam int FILL_W  = $clog2(LINE_BYTES);
    localparam int LEN_W   = $clog2(FIELD_CHARS + 1);
    localparam int NIDX_W  = $clog2(FIELD_CHARS);
    localparam int INT_W   = 33 - FRACTION_BITS;
    localparam int NUM_W   = 20 + FRACTION_BITS;
    localparam int DIV_CNT = NUM_W;
    localparam int DCNT_W  = $clog2(DIV_CNT + 1);
    localparam logic [INT_W-1:0] INT_CAP = INT_W'(1) << (32 - FRACTION_BITS);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BYTES - 3);

    logic [FILL_W-1:0]  fill_reg;
    logic               open_reg;
    logic [3:0]         ppos_reg;
    logic               pgood_reg;
    phase_t             phase_reg;
    logic [7:0]         name_reg [FIELD_CHARS];
    logic [LEN_W-1:0]   nlen_reg;
    logic [LEN_W-1:0]   vlen_reg;
    logic               neg_reg;
    logic [INT_W-1:0]   int_reg;
    logic [19:0]        frac_reg;
    logic [FRAC_CNT_W-1:0] fdig_reg;
    logic               stop_reg;

    logic [3:0]         mk_reg;
    logic               found_reg;
    logic [3:0]         found_idx_reg;

    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [19:0]        div_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [NUM_W-1:0]   num_shift_reg;

    logic               err_reg;
    logic [3:0]         idx_reg;
    logic [31:0]        val_reg;

    logic is_close;
    logic is_open;
    logic in_prefix;
    logic is_digit;
    logic [3:0] digit;
    logic [FRAC_CNT_W-1:0] kept;
    logic [INT_W+3:0] int_mul;
    logic name_hit;
    logic [NUM_W:0] rem_try;
    logic [32+FRACTION_BITS-1:0] mag;

    assign is_close  = (rx_byte == CH_CLOSE);
    assign is_open   = (rx_byte == CH_OPEN);
    assign in_prefix = (ppos_reg < 4'(PREFIX_LEN));
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit     = rx_byte[3:0];
    assign int_mul   = {int_reg, 3'b000} + {2'b00, int_reg, 1'b0} + (INT_W+4)'(digit);
    assign kept      = (fdig_reg == '0) ? '0 : fdig_reg - 1'b1;

    assign sts.close_result = (fill_reg != FILL_LIMIT) && is_close && open_reg;
    assign sts.close_error  = !(pgood_reg && (ppos_reg >= 4'(PREFIX_LEN))
                                && (phase_reg == PH_VALUE));
    assign sts.match_last   = (mk_reg == 4'(NAME_COUNT - 1));
    assign sts.div_last     = (dcnt_reg == DCNT_W'(1));

    always_comb
    begin
        logic [NAME_MAX*8-1:0] s;
        s        = name_text(mk_reg);
        name_hit = (nlen_reg == LEN_W'(name_len(mk_reg)));
        for (int i = 0; i < NAME_MAX; i++)
        begin
            if (i < FIELD_CHARS && i < int'(name_len(mk_reg)))
            begin
                if (name_reg[i] != s[(NAME_MAX-1-i)*8 +: 8])
                begin
                    name_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            open_reg  <= 1'b0;
            ppos_reg  <= '0;
            pgood_reg <= 1'b0;
            phase_reg <= PH_NAME;
            nlen_reg  <= '0;
            vlen_reg  <= '0;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            fill_reg  <= '0;
            open_reg  <= 1'b0;
            ppos_reg  <= '0;
            pgood_reg <= 1'b0;
            phase_reg <= PH_NAME;
            nlen_reg  <= '0;
            vlen_reg  <= '0;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else if (cmd.take_byte)
        begin
            if (!(fill_reg == FILL_LIMIT || is_close))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (fill_reg == FILL_LIMIT || is_close)
            begin
                // A close with a result keeps the frame until the beat leaves.
                if (!(fill_reg != FILL_LIMIT && open_reg))
                begin
                    fill_reg  <= '0;
                    open_reg  <= 1'b0;
                    ppos_reg  <= '0;
                    pgood_reg <= 1'b0;
                    phase_reg <= PH_NAME;
                    nlen_reg  <= '0;
                    vlen_reg  <= '0;
                    neg_reg   <= 1'b0;
                    int_reg   <= '0;
                    frac_reg  <= '0;
                    fdig_reg  <= '0;
                    stop_reg  <= 1'b0;
                end
            end
            else if (is_open)
            begin
                open_reg  <= 1'b1;
                ppos_reg  <= 4'd1;
                pgood_reg <= 1'b1;
                phase_reg <= PH_NAME;
                nlen_reg  <= '0;
                vlen_reg  <= '0;
                neg_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                fdig_reg  <= '0;
                stop_reg  <= 1'b0;
            end
            else if (open_reg)
            begin
                if (in_prefix)
                begin
                    if (rx_byte != prefix_char(ppos_reg[2:0]))
                    begin
                        pgood_reg <= 1'b0;
                    end
                    ppos_reg <= ppos_reg + 1'b1;
                end
                else if (pgood_reg)
                begin
                    if (phase_reg == PH_NAME)
                    begin
                        if (rx_byte == CH_COMMA)
                        begin
                            phase_reg <= PH_VALUE;
                        end
                        else if (nlen_reg < LEN_W'(FIELD_CHARS))
                        begin
                            nlen_reg <= nlen_reg + 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_LONG;
                        end
                    end
                    else if (phase_reg == PH_VALUE && vlen_reg < LEN_W'(FIELD_CHARS))
                    begin
                        vlen_reg <= vlen_reg + 1'b1;
                        if (!stop_reg)
                        begin
                            if (vlen_reg == '0 && (rx_byte == CH_MINUS || rx_byte == CH_PLUS))
                            begin
                                neg_reg <= (rx_byte == CH_MINUS);
                            end
                            else if (is_digit)
                            begin
                                if (fdig_reg == '0)
                                begin
                                    if (int_mul > (INT_W+4)'(INT_CAP))
                                    begin
                                        int_reg <= INT_CAP;
                                    end
                                    else
                                    begin
                                        int_reg <= int_mul[INT_W-1:0];
                                    end
                                end
                                else if (fdig_reg <= FRAC_CNT_W'(FRAC_KEEP))
                                begin
                                    frac_reg <= 20'({frac_reg, 3'b000} + {frac_reg, 1'b0}
                                                    + 23'(digit));
                                    fdig_reg <= fdig_reg + 1'b1;
                                end
                            end
                            else if (rx_byte == CH_DOT && fdig_reg == '0)
                            begin
                                fdig_reg <= FRAC_CNT_W'(1);
                            end
                            else
                            begin
                                stop_reg <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Name store: written only, never cleared.
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && !is_close && !is_open && fill_reg != FILL_LIMIT && open_reg
            && !in_prefix && pgood_reg && phase_reg == PH_NAME && rx_byte != CH_COMMA
            && nlen_reg < LEN_W'(FIELD_CHARS))
        begin
            name_reg[nlen_reg[NIDX_W-1:0]] <= rx_byte;
        end
    end

    // Name search, one candidate a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mk_reg        <= '0;
            found_reg     <= 1'b0;
            found_idx_reg <= '0;
        end
        else if (cmd.take_byte)
        begin
            mk_reg    <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.match_step)
        begin
            mk_reg <= mk_reg + 1'b1;
            if (name_hit && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= mk_reg;
            end
        end
    end

    assign rem_try = {rem_reg, num_shift_reg[NUM_W-1]} - {{(NUM_W-19){1'b0}}, div_reg};

    // Restoring divider for the rounded fraction, one quotient bit a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.conv_start)
        begin
            div_reg       <= pow_ten(kept > FRAC_CNT_W'(FRAC_KEEP) ? FRAC_CNT_W'(FRAC_KEEP)
                                                                   : kept);
            num_shift_reg <= NUM_W'({frac_reg, FRACTION_BITS'(0)})
                             + NUM_W'(pow_ten(kept) >> 1);
            rem_reg       <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= DCNT_W'(DIV_CNT);
        end
        else if (cmd.div_step)
        begin
            num_shift_reg <= num_shift_reg << 1;
            dcnt_reg      <= dcnt_reg - 1'b1;
            if (!rem_try[NUM_W])
            begin
                rem_reg <= rem_try[NUM_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[NUM_W-2:0], num_shift_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign mag = (32+FRACTION_BITS)'({int_reg, FRACTION_BITS'(0)})
               + (32+FRACTION_BITS)'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
            idx_reg <= '0;
            val_reg <= '0;
        end
        else if (cmd.take_byte && sts.close_result && sts.close_error)
        begin
            err_reg <= 1'b1;
            idx_reg <= '0;
            val_reg <= '0;
        end
        else if (cmd.sum_load)
        begin
            if (!found_reg)
            begin
                err_reg <= 1'b1;
                idx_reg <= '0;
                val_reg <= '0;
            end
            else
            begin
                err_reg <= 1'b0;
                idx_reg <= found_idx_reg;
                if (neg_reg)
                begin
                    val_reg <= (mag > (32+FRACTION_BITS)'(33'h080000000)) ? 32'h80000000
                             : 32'(0) - mag[31:0];
                end
                else
                begin
                    val_reg <= (mag > (32+FRACTION_BITS)'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                             : mag[31:0];
                end
            end
        end
    end

    assign param_index = idx_reg;
    assign param_value = val_reg;
    assign name_error  = err_reg;

endmodule
